// ----- rtl/core/quaternion_to_servo_angles_defines.svh -----
// Assertion helpers used by the core module
`ifndef QUATERNION_TO_SERVO_ANGLES_DEFINES_SVH
`define QUATERNION_TO_SERVO_ANGLES_DEFINES_SVH

// Checked while out of reset
`define Q2SA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked through reset as well
`define Q2SA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/q2sa_pkg.sv -----
package q2sa_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int CORDIC_STAGES   = 16;

    localparam int QUAT_W   = 16;
    localparam int ANG_W    = 17;
    localparam int YSRV_W   = 15;
    localparam int PSRV_W   = 13;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;
    localparam int CORD_W   = 36;
    localparam int ATAN_LEN = 24;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [YSRV_W-1:0] YAW_SERVO_MAX   = 15'd23040;
    localparam logic [PSRV_W-1:0] PITCH_SERVO_MAX = 13'd6400;

    typedef enum logic [1:0] {
        REG_YAW_RIGHT    = 2'd0,
        REG_YAW_LEFT     = 2'd1,
        REG_PITCH_TOP    = 2'd2,
        REG_PITCH_BOTTOM = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        SEL_QUOT     = 2'd0,
        SEL_MAX_QUOT = 2'd1,
        SEL_MAX      = 2'd2,
        SEL_ZERO     = 2'd3
    } t_sel;

endpackage

// ----- rtl/core/q2sa_if.sv -----
interface q2sa_in_if;
    import q2sa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

interface q2sa_out_if;
    import q2sa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ANG_W-1:0]  roll_scaled;
    logic [ANG_W-1:0]  pitch_scaled;
    logic [ANG_W-1:0]  yaw_scaled;
    logic [YSRV_W-1:0] yaw_servo;
    logic [PSRV_W-1:0] pitch_servo;

    modport source (output valid, output roll_scaled, output pitch_scaled,
                    output yaw_scaled, output yaw_servo, output pitch_servo, input ready);
    modport sink   (input valid, input roll_scaled, input pitch_scaled,
                    input yaw_scaled, input yaw_servo, input pitch_servo, output ready);
endinterface

// ----- rtl/core/q2sa_cordic.sv -----
module q2sa_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [q2sa_pkg::CORD_W-1:0] i_y,
    input  logic signed [q2sa_pkg::CORD_W-1:0] i_x,
    output logic        [31:0]                 o_th
);
    import q2sa_pkg::*;

    localparam int NS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    logic signed [CORD_W-1:0] r_x   [NS+1];
    logic signed [CORD_W-1:0] r_y   [NS+1];
    logic        [31:0]       r_th  [NS+1];
    logic                     r_byp [NS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y == '0) begin
                r_byp[0] <= 1'b1;
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_th[0]  <= (i_x < 0) ? HALF_TURN : '0;
            end else if (i_x < 0) begin
                r_byp[0] <= 1'b0;
                r_x[0]   <= -i_x;
                r_y[0]   <= -i_y;
                r_th[0]  <= HALF_TURN;
            end else begin
                r_byp[0] <= 1'b0;
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_th[0]  <= '0;
            end
            for (int i = 0; i < NS; i++) begin
                r_byp[i+1] <= r_byp[i];
                if (r_byp[i]) begin
                    r_x[i+1]  <= r_x[i];
                    r_y[i+1]  <= r_y[i];
                    r_th[i+1] <= r_th[i];
                end else if (r_y[i] > 0) begin
                    r_x[i+1]  <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1]  <= r_y[i] - (r_x[i] >>> i);
                    r_th[i+1] <= r_th[i] + ATAN_TAB[i];
                end else begin
                    r_x[i+1]  <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1]  <= r_y[i] + (r_x[i] >>> i);
                    r_th[i+1] <= r_th[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign o_th = r_th[NS];

endmodule

// ----- rtl/core/quaternion_to_servo_angles.sv -----
// Quaternion to roll/pitch/yaw and two servo angles.
// Input channel i_in carries one Q1.15 quaternion per transfer; output channel
// o_out carries the three angles scaled onto 0..18 (Q5.12) and the yaw and
// pitch servo angles (Q7.8 and Q5.8). Both use valid/ready; a transfer
// happens when both are high. Calibration limits sit in four APB registers
// at byte addresses 0, 4, 8 and 12 (yaw right, yaw left, pitch top, pitch
// bottom); write them only while no item is in flight.
// From input transfer to output valid an item passes through products, sums,
// a square, a 16-stage square root (two root bits per stage), CORDIC_STAGES + 1
// vectoring stages, scaling, servo set-up, a 15-stage restoring divider (one
// quotient bit per stage) and a result stage. Throughput is one item per cycle
// unless the pipeline holds; every unit is fully pipelined.
// A two-entry output buffer follows the pipeline, so the pipeline keeps
// moving while one result waits. With both entries full and a result in the
// last stage the whole pipeline holds and i_in.ready drops; nothing is lost.
// Reset clears all valid bits, the output buffer's pointers and count, and
// the calibration registers to zero.
`include "quaternion_to_servo_angles_defines.svh"

module quaternion_to_servo_angles (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    q2sa_in_if.sink                         i_in,
    q2sa_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [q2sa_pkg::CFG_AW-1:0]     paddr,
    input  logic [q2sa_pkg::CFG_DW-1:0]     pwdata,
    output logic [q2sa_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import q2sa_pkg::*;

    localparam int ISQ_ITER = 31;
    localparam int ISQ_PER  = 2;
    localparam int NISQ     = (ISQ_ITER + ISQ_PER - 1) / ISQ_PER;
    localparam int NCORD    = ((CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN) + 1;
    localparam int NDIV     = YSRV_W;
    localparam int NST      = 3 + NISQ + NCORD + 2 + NDIV + 1;

    localparam int SH_FULL  = 32 - ANGLE_FRAC_BITS;
    localparam int SH_HALF  = 31 - ANGLE_FRAC_BITS;
    localparam int LIM_I    = ((18 << ANGLE_FRAC_BITS) > ((1 << ANG_W) - 1)) ?
                              ((1 << ANG_W) - 1) : (18 << ANGLE_FRAC_BITS);
    localparam logic [ANG_W-1:0] SCL_LIM = ANG_W'(LIM_I);

    typedef struct packed {
        logic signed [31:0] wx, yz, xx, yy, wz, xy, zz, wy, zx;
    } t_prod;

    typedef struct packed {
        logic signed [33:0] ry, rx, yy, yx;
        logic signed [31:0] t;
    } t_vec;

    typedef struct packed {
        logic [60:0] v;
        logic [60:0] r;
    } t_isq;

    typedef struct packed {
        logic [ANG_W-1:0] roll, pitch, yaw;
    } t_scl;

    typedef struct packed {
        logic [31:0]       rem_y;
        logic [ANG_W-1:0]  span_y;
        logic [YSRV_W-1:0] q_y;
        logic [31:0]       rem_p;
        logic [ANG_W-1:0]  span_p;
        logic [YSRV_W-1:0] q_p;
        t_sel              sel_y;
        t_sel              sel_p;
        t_scl              ang;
    } t_srv;

    typedef struct packed {
        t_scl              ang;
        logic [YSRV_W-1:0] yaw_servo;
        logic [PSRV_W-1:0] pitch_servo;
    } t_out;

    function automatic t_isq isq_stage(input t_isq a, input int s);
        t_isq        o;
        logic [60:0] b;
        int          j;
        o = a;
        for (int m = 0; m < ISQ_PER; m++) begin
            j = s * ISQ_PER + m;
            if (j < ISQ_ITER) begin
                b = 61'(1) << (60 - 2 * j);
                if (o.v >= o.r + b) begin
                    o.v = o.v - (o.r + b);
                    o.r = (o.r >> 1) + b;
                end else begin
                    o.r = o.r >> 1;
                end
            end
        end
        return o;
    endfunction

    function automatic logic [ANG_W-1:0] sat_scl(input logic [37:0] v);
        return (v > 38'(SCL_LIM)) ? SCL_LIM : v[ANG_W-1:0];
    endfunction

    function automatic logic [ANG_W-1:0] scale_full(input logic [31:0] th);
        logic [32:0] off;
        logic [37:0] p;
        off = (th == HALF_TURN) ? {1'b1, 32'h0} : {1'b0, th + HALF_TURN};
        p   = 38'(off) * 38'd18 + (38'd1 << (SH_FULL - 1));
        return sat_scl(p >> SH_FULL);
    endfunction

    function automatic logic [ANG_W-1:0] scale_half(input logic [31:0] th);
        logic signed [33:0] off;
        logic        [37:0] p;
        off = 34'(signed'(th)) + (34'sd1 <<< 30);
        if (off < 0) begin
            off = '0;
        end
        p = 38'(off[32:0]) * 38'd18 + (38'd1 << (SH_HALF - 1));
        return sat_scl(p >> SH_HALF);
    endfunction

    logic [ANG_W-1:0] r_yaw_right, r_yaw_left, r_pitch_top, r_pitch_bottom;

    logic [NST-1:0]   r_v;
    logic             en;
    logic             push;
    logic             pop;

    t_prod            r_prod;
    t_vec             r_sum;
    t_vec             r_vec [NISQ+1];
    t_isq             r_isq [NISQ+1];
    t_scl             r_scl;
    t_srv             r_srv [NDIV+1];
    t_out             r_fin;
    t_out             n_fin;
    t_srv             n_srv;

    t_out             r_ob [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_ocnt;

    logic signed [CORD_W-1:0] roll_y, roll_x, yaw_y, yaw_x, pit_y, pit_x;
    logic [31:0]      th_roll, th_yaw, th_pitch;

    // APB
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_right    <= '0;
            r_yaw_left     <= '0;
            r_pitch_top    <= '0;
            r_pitch_bottom <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg'(paddr[3:2]))
                REG_YAW_RIGHT:    r_yaw_right    <= pwdata[ANG_W-1:0];
                REG_YAW_LEFT:     r_yaw_left     <= pwdata[ANG_W-1:0];
                REG_PITCH_TOP:    r_pitch_top    <= pwdata[ANG_W-1:0];
                REG_PITCH_BOTTOM: r_pitch_bottom <= pwdata[ANG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_YAW_RIGHT:    prdata = CFG_DW'(r_yaw_right);
            REG_YAW_LEFT:     prdata = CFG_DW'(r_yaw_left);
            REG_PITCH_TOP:    prdata = CFG_DW'(r_pitch_top);
            REG_PITCH_BOTTOM: prdata = CFG_DW'(r_pitch_bottom);
        endcase
    end

    // Pipeline control
    assign push       = r_v[NST-1] && (r_ocnt != 2'd2);
    assign en         = !r_v[NST-1] || (r_ocnt != 2'd2);
    assign pop        = o_out.valid && o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_in.valid};
        end
    end

    // Products, sums, square, root
    always_ff @(posedge i_clk) begin
        logic signed [33:0] t34;
        logic        [31:0] at;
        logic        [61:0] tt;
        if (en) begin
            r_prod.wx <= 32'(i_in.quat_w) * 32'(i_in.quat_x);
            r_prod.yz <= 32'(i_in.quat_y) * 32'(i_in.quat_z);
            r_prod.xx <= 32'(i_in.quat_x) * 32'(i_in.quat_x);
            r_prod.yy <= 32'(i_in.quat_y) * 32'(i_in.quat_y);
            r_prod.wz <= 32'(i_in.quat_w) * 32'(i_in.quat_z);
            r_prod.xy <= 32'(i_in.quat_x) * 32'(i_in.quat_y);
            r_prod.zz <= 32'(i_in.quat_z) * 32'(i_in.quat_z);
            r_prod.wy <= 32'(i_in.quat_w) * 32'(i_in.quat_y);
            r_prod.zx <= 32'(i_in.quat_z) * 32'(i_in.quat_x);

            r_sum.ry <= (34'(r_prod.wx) + 34'(r_prod.yz)) <<< 1;
            r_sum.rx <= (34'sd1 <<< 30) - ((34'(r_prod.xx) + 34'(r_prod.yy)) <<< 1);
            r_sum.yy <= (34'(r_prod.wz) + 34'(r_prod.xy)) <<< 1;
            r_sum.yx <= (34'sd1 <<< 30) - ((34'(r_prod.yy) + 34'(r_prod.zz)) <<< 1);
            t34 = (34'(r_prod.wy) - 34'(r_prod.zx)) <<< 1;
            if (t34 > (34'sd1 <<< 30)) begin
                t34 = 34'sd1 <<< 30;
            end else if (t34 < -(34'sd1 <<< 30)) begin
                t34 = -(34'sd1 <<< 30);
            end
            r_sum.t <= 32'(t34);

            at = (r_sum.t < 0) ? 32'(-r_sum.t) : 32'(r_sum.t);
            tt = 62'(at[30:0]) * 62'(at[30:0]);
            r_vec[0]   <= r_sum;
            r_isq[0].v <= (61'd1 << 60) - tt[60:0];
            r_isq[0].r <= '0;

            for (int s = 0; s < NISQ; s++) begin
                r_vec[s+1] <= r_vec[s];
                r_isq[s+1] <= isq_stage(r_isq[s], s);
            end
        end
    end

    // CORDIC units
    assign roll_y = CORD_W'(r_vec[NISQ].ry);
    assign roll_x = CORD_W'(r_vec[NISQ].rx);
    assign yaw_y  = CORD_W'(r_vec[NISQ].yy);
    assign yaw_x  = CORD_W'(r_vec[NISQ].yx);
    assign pit_y  = CORD_W'(r_vec[NISQ].t);
    assign pit_x  = CORD_W'(r_isq[NISQ].r[30:0]);

    q2sa_cordic u_cordic_roll (
        .i_clk (i_clk), .i_en (en), .i_y (roll_y), .i_x (roll_x), .o_th (th_roll)
    );

    q2sa_cordic u_cordic_yaw (
        .i_clk (i_clk), .i_en (en), .i_y (yaw_y), .i_x (yaw_x), .o_th (th_yaw)
    );

    q2sa_cordic u_cordic_pitch (
        .i_clk (i_clk), .i_en (en), .i_y (pit_y), .i_x (pit_x), .o_th (th_pitch)
    );

    // Servo set-up
    always_comb begin
        logic        [ANG_W-1:0] cy, cp;
        logic signed [ANG_W:0]   dif_y, span_y, dif_p, span_p;
        logic                    ge;
        cy = r_scl.yaw;
        cp = r_scl.pitch;
        ge = (r_yaw_right >= r_yaw_left);
        if (ge) begin
            dif_y  = signed'({1'b0, cy}) - signed'({1'b0, r_yaw_left});
            span_y = signed'({1'b0, r_yaw_right}) - signed'({1'b0, r_yaw_left});
        end else begin
            dif_y  = signed'({1'b0, cy}) - signed'({1'b0, r_yaw_right});
            span_y = signed'({1'b0, r_yaw_left}) - signed'({1'b0, r_yaw_right});
        end
        dif_p  = signed'({1'b0, cp}) - signed'({1'b0, r_pitch_bottom});
        span_p = signed'({1'b0, r_pitch_top}) - signed'({1'b0, r_pitch_bottom});

        if (ge) begin
            priority if (cy > r_yaw_right) begin
                n_srv.sel_y = SEL_ZERO;
            end else if (cy < r_yaw_left) begin
                n_srv.sel_y = SEL_MAX;
            end else if (span_y <= 0 || dif_y < 0) begin
                n_srv.sel_y = SEL_MAX;
            end else begin
                n_srv.sel_y = SEL_MAX_QUOT;
            end
        end else begin
            priority if (cy < r_yaw_right) begin
                n_srv.sel_y = SEL_ZERO;
            end else if (cy > r_yaw_left) begin
                n_srv.sel_y = SEL_MAX;
            end else if (span_y <= 0 || dif_y < 0) begin
                n_srv.sel_y = SEL_ZERO;
            end else begin
                n_srv.sel_y = SEL_QUOT;
            end
        end

        priority if (cp < r_pitch_bottom) begin
            n_srv.sel_p = SEL_ZERO;
        end else if (cp > r_pitch_top) begin
            n_srv.sel_p = SEL_MAX;
        end else if (span_p <= 0 || dif_p < 0) begin
            n_srv.sel_p = SEL_ZERO;
        end else begin
            n_srv.sel_p = SEL_QUOT;
        end

        n_srv.rem_y  = 32'(dif_y[ANG_W-1:0]) * 32'(YAW_SERVO_MAX) + 32'(span_y[ANG_W-1:1]);
        n_srv.span_y = span_y[ANG_W-1:0];
        n_srv.q_y    = '0;
        n_srv.rem_p  = 32'(dif_p[ANG_W-1:0]) * 32'(PITCH_SERVO_MAX) + 32'(span_p[ANG_W-1:1]);
        n_srv.span_p = span_p[ANG_W-1:0];
        n_srv.q_p    = '0;
        n_srv.ang    = r_scl;
    end

    // Result selection
    always_comb begin
        logic [YSRV_W-1:0] qy, qp;
        qy = (r_srv[NDIV].q_y > YAW_SERVO_MAX) ? YAW_SERVO_MAX : r_srv[NDIV].q_y;
        qp = (r_srv[NDIV].q_p > YSRV_W'(PITCH_SERVO_MAX)) ?
             YSRV_W'(PITCH_SERVO_MAX) : r_srv[NDIV].q_p;
        n_fin.ang = r_srv[NDIV].ang;
        unique case (r_srv[NDIV].sel_y)
            SEL_QUOT:     n_fin.yaw_servo = qy;
            SEL_MAX_QUOT: n_fin.yaw_servo = YAW_SERVO_MAX - qy;
            SEL_MAX:      n_fin.yaw_servo = YAW_SERVO_MAX;
            SEL_ZERO:     n_fin.yaw_servo = '0;
        endcase
        unique case (r_srv[NDIV].sel_p)
            SEL_QUOT:     n_fin.pitch_servo = qp[PSRV_W-1:0];
            SEL_MAX_QUOT: n_fin.pitch_servo = PITCH_SERVO_MAX - qp[PSRV_W-1:0];
            SEL_MAX:      n_fin.pitch_servo = PITCH_SERVO_MAX;
            SEL_ZERO:     n_fin.pitch_servo = '0;
        endcase
    end

    // Scaling, divider, result
    always_ff @(posedge i_clk) begin
        logic [31:0] dv;
        t_srv        sv;
        if (en) begin
            r_scl.roll  <= scale_full(th_roll);
            r_scl.yaw   <= scale_full(th_yaw);
            r_scl.pitch <= scale_half(th_pitch);

            r_srv[0] <= n_srv;
            for (int d = 0; d < NDIV; d++) begin
                sv = r_srv[d];
                dv = 32'(r_srv[d].span_y) << (NDIV - 1 - d);
                if (sv.rem_y >= dv) begin
                    sv.rem_y             = sv.rem_y - dv;
                    sv.q_y[NDIV - 1 - d] = 1'b1;
                end
                dv = 32'(r_srv[d].span_p) << (NDIV - 1 - d);
                if (sv.rem_p >= dv) begin
                    sv.rem_p             = sv.rem_p - dv;
                    sv.q_p[NDIV - 1 - d] = 1'b1;
                end
                r_srv[d+1] <= sv;
            end

            r_fin <= n_fin;
        end
    end

    // Output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_ocnt <= r_ocnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob[r_wp] <= r_fin;
        end
    end

    assign o_out.valid        = (r_ocnt != 2'd0);
    assign o_out.roll_scaled  = r_ob[r_rp].ang.roll;
    assign o_out.pitch_scaled = r_ob[r_rp].ang.pitch;
    assign o_out.yaw_scaled   = r_ob[r_rp].ang.yaw;
    assign o_out.yaw_servo    = r_ob[r_rp].yaw_servo;
    assign o_out.pitch_servo  = r_ob[r_rp].pitch_servo;

    `Q2SA_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out.valid, "output valid after reset")
    `Q2SA_ASSERT(a_yaw_range, o_out.valid |-> (o_out.yaw_servo <= YAW_SERVO_MAX), "yaw servo range")
    `Q2SA_ASSERT(a_pitch_range, o_out.valid |-> (o_out.pitch_servo <= PITCH_SERVO_MAX), "pitch servo range")
    `Q2SA_ASSERT(a_buf_full_hold, (r_ocnt == 2'd2 && !o_out.ready) |=> (r_ocnt == 2'd2), "buffer overrun")

endmodule

// ----- tb/tb_quaternion_to_servo_angles.sv -----
module tb_quaternion_to_servo_angles;
    timeunit 1ns;
    timeprecision 1ps;
    import q2sa_pkg::*;

    localparam int  RAND_PER_PHASE = 240;
    localparam int  SETTLE_CYCLES  = CORDIC_STAGES + 38 + 10;
    localparam int  IDLE_LIMIT     = 4000;
    localparam longint ONE_Q30     = 64'd1 << 30;
    localparam longint SCALE_LIM   = ((18 << ANGLE_FRAC_BITS) > 131071) ? 131071
                                                                       : (18 << ANGLE_FRAC_BITS);

    typedef struct {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic [ANG_W-1:0]  roll;
        logic [ANG_W-1:0]  pitch;
        logic [ANG_W-1:0]  yaw;
        logic [YSRV_W-1:0] ysrv;
        logic [PSRV_W-1:0] psrv;
    } t_angles;

    typedef struct {
        t_quat   q;
        bit      typed;
        t_angles ang;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    q2sa_in_if  in_if ();
    q2sa_out_if out_if ();

    quaternion_to_servo_angles dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [ANG_W-1:0] cal_yaw_right, cal_yaw_left, cal_pitch_top, cal_pitch_bottom;
    t_angles          pending_angles [$];
    int               mismatches;
    int               items_sent;
    int               results_seen;
    int               idle_cycles;
    int               phases_run;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bit_v;
        res   = 0;
        bit_v = 64'd1 << 60;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] th;
        longint      xs, ys;
        th = 32'd0;
        if (y == 0) return (x < 0) ? HALF_TURN : 32'd0;
        if (x < 0) begin
            x  = -x;
            y  = -y;
            th = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x  = x + ys;
                y  = y - xs;
                th = th + ATAN_TAB[i];
            end else begin
                x  = x - ys;
                y  = y + xs;
                th = th - ATAN_TAB[i];
            end
        end
        return th;
    endfunction

    function automatic longint clip_scaled(longint v);
        return (v > SCALE_LIM) ? SCALE_LIM : v;
    endfunction

    function automatic longint full_turn_scaled(logic [31:0] th);
        longint off;
        int     sh;
        logic [31:0] sum;
        sh  = 32 - ANGLE_FRAC_BITS;
        sum = th + HALF_TURN;
        off = (th == HALF_TURN) ? (64'd1 << 32) : longint'({32'd0, sum});
        return clip_scaled((off * 18 + (64'd1 << (sh - 1))) >>> sh);
    endfunction

    function automatic longint half_turn_scaled(logic [31:0] th);
        longint off;
        int     sh;
        sh  = 31 - ANGLE_FRAC_BITS;
        off = longint'(signed'(th)) + ONE_Q30;
        if (off < 0) off = 0;
        return clip_scaled((off * 18 + (64'd1 << (sh - 1))) >>> sh);
    endfunction

    function automatic longint servo_ratio(longint dif, longint span, longint full);
        if (span <= 0 || dif < 0) return 0;
        return (dif * full + span / 2) / span;
    endfunction

    function automatic t_angles predict_angles(t_quat q);
        longint  w, x, y, z, t, c, cy, cp, rt, lf, tp, bt, dy, dp;
        t_angles a;
        w = q.w; x = q.x; y = q.y; z = q.z;
        a.roll = ANG_W'(full_turn_scaled(vector_angle(2 * (w * x + y * z),
                                                      ONE_Q30 - 2 * (x * x + y * y))));
        a.yaw  = ANG_W'(full_turn_scaled(vector_angle(2 * (w * z + x * y),
                                                      ONE_Q30 - 2 * (y * y + z * z))));
        t = 2 * (w * y - z * x);
        if (t > ONE_Q30) t = ONE_Q30;
        if (t < -ONE_Q30) t = -ONE_Q30;
        c = longint'(root64((64'd1 << 60) - longint'(t * t)));
        a.pitch = ANG_W'(half_turn_scaled(vector_angle(t, c)));

        cy = a.yaw; cp = a.pitch;
        rt = cal_yaw_right; lf = cal_yaw_left; tp = cal_pitch_top; bt = cal_pitch_bottom;
        if (rt >= lf) begin
            dy = 23040 - servo_ratio(cy - lf, rt - lf, 23040);
            if (cy < lf) dy = 23040;
            if (cy > rt) dy = 0;
        end else begin
            dy = servo_ratio(cy - rt, lf - rt, 23040);
            if (cy > lf) dy = 23040;
            if (cy < rt) dy = 0;
        end
        dp = servo_ratio(cp - bt, tp - bt, 6400);
        if (cp > tp) dp = 6400;
        if (cp < bt) dp = 0;
        a.ysrv = YSRV_W'((dy < 0) ? 0 : ((dy > 23040) ? 23040 : dy));
        a.psrv = PSRV_W'((dp < 0) ? 0 : ((dp > 6400) ? 6400 : dp));
        return a;
    endfunction

    function automatic t_quat random_quat();
        t_quat q;
        real   c [4];
        real   n;
        int    sparse;
        if ($urandom_range(0, 3) == 0) begin
            q.w = QUAT_W'($urandom);
            q.x = QUAT_W'($urandom);
            q.y = QUAT_W'($urandom);
            q.z = QUAT_W'($urandom);
            return q;
        end
        sparse = $urandom_range(0, 4);
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
            if (sparse == 0 && $urandom_range(0, 1) == 0) c[i] = 0.0;
            n = n + c[i] * c[i];
        end
        if (n == 0.0) begin
            c[0] = 1.0;
            n    = 1.0;
        end
        n = $sqrt(n);
        q.w = QUAT_W'($rtoi(c[0] / n * 32767.0));
        q.x = QUAT_W'($rtoi(c[1] / n * 32767.0));
        q.y = QUAT_W'($rtoi(c[2] / n * 32767.0));
        q.z = QUAT_W'($rtoi(c[3] / n * 32767.0));
        return q;
    endfunction

    task automatic write_cal(t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_AW'(idx) << 2;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_YAW_RIGHT:    cal_yaw_right    = value[ANG_W-1:0];
            REG_YAW_LEFT:     cal_yaw_left     = value[ANG_W-1:0];
            REG_PITCH_TOP:    cal_pitch_top    = value[ANG_W-1:0];
            REG_PITCH_BOTTOM: cal_pitch_bottom = value[ANG_W-1:0];
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_quat(t_quat q);
        in_if.valid  = 1'b1;
        in_if.quat_w = q.w;
        in_if.quat_x = q.x;
        in_if.quat_y = q.y;
        in_if.quat_z = q.z;
        do @(posedge i_clk); while (!in_if.ready);
        pending_angles.push_back(predict_angles(q));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        in_if.valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_burst_run(int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            send_quat(random_quat());
            burst--;
        end
        pause_sender(0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            t_angles e;
            results_seen++;
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer on output channel");
            end else begin
                e = pending_angles.pop_front();
                if (out_if.roll_scaled !== e.roll || out_if.pitch_scaled !== e.pitch ||
                    out_if.yaw_scaled !== e.yaw || out_if.yaw_servo !== e.ysrv ||
                    out_if.pitch_servo !== e.psrv) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: exp r=%0d p=%0d y=%0d ys=%0d ps=%0d",
                                 results_seen, e.roll, e.pitch, e.yaw, e.ysrv, e.psrv);
                        $display("           got r=%0d p=%0d y=%0d ys=%0d ps=%0d",
                                 out_if.roll_scaled, out_if.pitch_scaled, out_if.yaw_scaled,
                                 out_if.yaw_servo, out_if.pitch_servo);
                    end
                end
            end
        end
    end

    int stall_mode;
    int stall_left;
    int mode_left;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            0: out_if.ready = 1'b1;
            1: out_if.ready = 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    out_if.ready = 1'b0;
                    stall_left--;
                end else begin
                    out_if.ready = 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 25);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_angles.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    t_row directed [] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{17'd36864, 17'd36864, 17'd36864, 15'd0, 13'd6400}},
        '{'{16'sd0, -16'sd32768, 16'sd0, 16'sd0}, 1'b1,
          '{17'd73728, 17'd36864, 17'd36864, 15'd0, 13'd6400}},
        '{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd0, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd0, 16'sd0, -16'sd32768, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd23170, 16'sd0, 16'sd23170, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd23170, 16'sd0, -16'sd23170, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd23171, 16'sd0, 16'sd23171, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd23171, 16'sd0, -16'sd23171, 16'sd0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd23170, 16'sd0, 16'sd0, 16'sd23170}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd23170, 16'sd0, 16'sd0, -16'sd23170}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd21845, -16'sd21846, 16'sd21845, -16'sd21846}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1}, 1'b0, '{0, 0, 0, 0, 0}}
    };

    logic [16:0] cal_sets [5][4] = '{
        '{17'd73728, 17'd0, 17'd73728, 17'd0},
        '{17'd0, 17'd73728, 17'd0, 17'd73728},
        '{17'd27000, 17'd45000, 17'd50000, 17'd20000},
        '{17'd45000, 17'd27000, 17'd36864, 17'd36864},
        '{17'd36864, 17'd36864, 17'd40000, 17'd30000}
    };

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_if.valid  = 1'b0;
        in_if.quat_w = '0;
        in_if.quat_x = '0;
        in_if.quat_y = '0;
        in_if.quat_z = '0;
        out_if.ready = 1'b0;
        stall_mode   = 0;
        stall_left   = 0;
        mode_left    = 0;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        phases_run   = 0;
        cal_yaw_right = '0; cal_yaw_left = '0; cal_pitch_top = '0; cal_pitch_bottom = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            if (directed[i].typed) begin
                t_angles p;
                p = predict_angles(directed[i].q);
                if (p != directed[i].ang) begin
                    mismatches++;
                    if (mismatches <= 10) $display("directed row %0d disagrees with predictor", i);
                end
            end
            send_quat(directed[i].q);
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 4));
        end
        pause_sender(0);
        random_burst_run(RAND_PER_PHASE);
        drain_results();
        phases_run++;

        for (int ph = 0; ph < 7; ph++) begin
            logic [31:0] v [4];
            for (int r = 0; r < 4; r++) begin
                v[r] = (ph < 5) ? {15'd0, cal_sets[ph][r]} : 32'($urandom_range(0, 73728));
                v[r][31:17] = 15'($urandom);
            end
            write_cal(REG_YAW_RIGHT,    v[0]);
            write_cal(REG_YAW_LEFT,     v[1]);
            write_cal(REG_PITCH_TOP,    v[2]);
            write_cal(REG_PITCH_BOTTOM, v[3]);
            foreach (directed[i]) if (!directed[i].typed) send_quat(directed[i].q);
            random_burst_run(RAND_PER_PHASE - 20);
            drain_results();
            phases_run++;
        end

        $display("sent %0d quaternions over %0d calibration settings, %0d results checked",
                 items_sent, phases_run, results_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
